// ----- hw/rtl/iir3_pkg.sv -----
// Shared types and constants for the third-order IIR filter.
package iir3_pkg;

  localparam int DATA_W     = 32;
  localparam int COEF_W     = 32;
  localparam int PROD_W     = DATA_W + COEF_W;
  // Seven products of 64 bits each need three guard bits.
  localparam int ACC_W      = PROD_W + 3;
  localparam int HIST_DEPTH = 3;
  localparam int NUM_COEFS  = 4;
  localparam int NUM_TAPS   = 7;
  localparam int TERM_W     = 3;
  localparam int DIV_STEPS  = 32;
  localparam int CNT_W      = 5;
  localparam int REG_IDX_W  = 3;
  localparam int STAT_W     = 2;

  // Configuration register indexes
  localparam logic [REG_IDX_W-1:0] REG_NUM0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_NUM1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_NUM2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NUM3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DEN0 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DEN1 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DEN2 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DEN3 = 3'd7;

  // a0 resets to 1.0 in Q8.24
  localparam logic [COEF_W-1:0] DEN0_RESET = 32'h0100_0000;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_SAT     = 2'd1;
  localparam logic [STAT_W-1:0] ST_A0_ZERO = 2'd2;

  // Input action codes
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  localparam logic [DATA_W-1:0] Y_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Y_MIN = 32'h8000_0000;

  typedef struct packed {
    logic              load;     // latch sample, clear accumulator
    logic              clear;    // zero both histories
    logic              mul_en;   // multiply selected term
    logic [TERM_W-1:0] term;     // term feeding the multiplier
    logic              acc_en;   // add registered product
    logic              acc_sub;  // subtract instead (feedback terms)
    logic              abs_en;   // take magnitude, prime divider
    logic              div_en;   // one quotient bit
    logic              finish;   // write result, shift histories
  } dp_cmd_t;

endpackage

// ----- hw/rtl/iir_filter_order3.sv -----
// Top level of the third-order direct-form-I IIR filter.
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata: sample; tuser: action
//  out_     master     out_tvalid/out_tready tdata: filtered; tuser: status
//  cfg_     write      cfg_wr_en            cfg_addr, cfg_wdata (8 coefficients)
//
// A sample goes from acceptance to a result in the output register through the
// single shared 32x32 multiplier and accumulator, the magnitude step, the
// bit-serial divider and the write-back.
// The input is ready again only after the write-back, so no new sample is taken while one is worked on.
// A clear item zeroes the histories and gives no result.
// Reset (rst_n low, synchronous) zeroes the histories and loads a0 = 1.0.
// A stalled output holds the write-back; the next item waits until then.
module iir_filter_order3 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [iir3_pkg::DATA_W-1:0]       in_tdata,   // [31:0] sample
  input  logic [0:0]                        in_tuser,   // [0] action
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [iir3_pkg::DATA_W-1:0]       out_tdata,  // [31:0] filtered
  output logic [iir3_pkg::STAT_W-1:0]       out_tuser,  // [1:0] status
  input  logic                              cfg_wr_en,
  input  logic [iir3_pkg::REG_IDX_W-1:0]    cfg_addr,
  input  logic [iir3_pkg::COEF_W-1:0]       cfg_wdata
);
  import iir3_pkg::*;

  dp_cmd_t cmd;

  iir3_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_action  (in_tuser[0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  iir3_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_sample    (in_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .out_filtered (out_tdata),
    .out_status   (out_tuser)
  );

`ifndef SYNTHESIS
  // A clear item never raises a result
  a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == ACT_CLEAR && !out_tvalid) |=> !out_tvalid)
    else $error("result raised by a clear item");

  // A filter item keeps the input side busy while it is worked on
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser[0] == ACT_FILTER) |=> !in_tready ##1 !in_tready)
    else $error("input taken during a filter item");

  // Status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_OK || out_tuser == ST_SAT || out_tuser == ST_A0_ZERO))
    else $error("undefined status code");

  // Saturated and a0-zero results sit at one of the limits
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tdata == Y_MAX || out_tdata == Y_MIN))
    else $error("saturated result off the limits");
`endif

endmodule

// ----- hw/rtl/iir3_ctrl.sv -----
// Sequencer for the IIR filter: multiply-accumulate, divide, result hand-off.
module iir3_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_action,
  output logic              out_tvalid,
  input  logic              out_tready,
  output iir3_pkg::dp_cmd_t cmd
);
  import iir3_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_ABS  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

  localparam logic [CNT_W-1:0] MAC_END   = CNT_W'(NUM_TAPS);
  localparam logic [CNT_W-1:0] DEN_FIRST = CNT_W'(NUM_COEFS + 1);
  localparam logic [CNT_W-1:0] DIV_END   = CNT_W'(DIV_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign out_tvalid = out_valid_r;
  assign in_tready  = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.term      = cnt_r[TERM_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_action == ACT_CLEAR) begin
            cmd.clear = 1'b1;
          end else begin
            cmd.load  = 1'b1;
            cnt_nxt   = '0;
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        // product of term k is added in the cycle after it is formed
        cmd.mul_en  = (cnt_r < MAC_END);
        cmd.acc_en  = (cnt_r != '0);
        cmd.acc_sub = (cnt_r >= DEN_FIRST);
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == MAC_END) begin
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        cmd.abs_en = 1'b1;
        cnt_nxt    = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
        if (cnt_r == DIV_END) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/iir3_dp.sv -----
// IIR filter datapath: coefficients, histories, shared multiplier, divider.
module iir3_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iir3_pkg::dp_cmd_t                   cmd,
  input  logic [iir3_pkg::DATA_W-1:0]         in_sample,
  input  logic                                cfg_wr_en,
  input  logic [iir3_pkg::REG_IDX_W-1:0]      cfg_addr,
  input  logic [iir3_pkg::COEF_W-1:0]         cfg_wdata,
  output logic [iir3_pkg::DATA_W-1:0]         out_filtered,
  output logic [iir3_pkg::STAT_W-1:0]         out_status
);
  import iir3_pkg::*;

  logic signed [COEF_W-1:0] num_r [NUM_COEFS];
  logic signed [COEF_W-1:0] den_r [NUM_COEFS];
  logic signed [DATA_W-1:0] ih_r  [HIST_DEPTH];
  logic signed [DATA_W-1:0] oh_r  [HIST_DEPTH];
  logic signed [DATA_W-1:0] x_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     neg_r;
  logic                     sat_hi_r;
  logic [DATA_W-1:0]        rem_r;
  logic [DATA_W-1:0]        quo_r;
  logic [DATA_W-1:0]        filt_r;
  logic [STAT_W-1:0]        stat_r;

  logic signed [COEF_W-1:0] coef_sel;
  logic signed [DATA_W-1:0] data_sel;
  logic [1:0]               ih_idx;
  logic [1:0]               oh_idx;
  logic [ACC_W-1:0]         mag;
  logic [COEF_W-1:0]        divisor;
  logic [DATA_W:0]          trial;
  logic                     trial_ge;
  logic [DATA_W:0]          trial_diff;
  logic                     q_neg;
  logic [DATA_W-1:0]        y;
  logic [STAT_W-1:0]        st;

  assign out_filtered = filt_r;
  assign out_status   = stat_r;

  // Operand select for the shared multiplier
  assign ih_idx = 2'(cmd.term - 3'd1);
  assign oh_idx = 2'(cmd.term - 3'(NUM_COEFS));

  always_comb begin
    if (cmd.term < TERM_W'(NUM_COEFS)) begin
      coef_sel = num_r[cmd.term[1:0]];
    end else begin
      coef_sel = den_r[2'(cmd.term - 3'(NUM_COEFS - 1))];
    end
    if (cmd.term == '0) begin
      data_sel = x_r;
    end else if (cmd.term < TERM_W'(NUM_COEFS)) begin
      data_sel = ih_r[ih_idx];
    end else begin
      data_sel = oh_r[oh_idx];
    end
  end

  // |a0| fits 32 unsigned bits, the most negative value included
  assign divisor = den_r[0][COEF_W-1] ? (~den_r[0] + 1'b1) : den_r[0];
  assign mag     = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;

  // One restoring division step
  assign trial      = {rem_r, quo_r[DATA_W-1]};
  assign trial_ge   = (trial >= {1'b0, divisor});
  assign trial_diff = trial - {1'b0, divisor};

  always_comb begin
    q_neg = neg_r ^ den_r[0][COEF_W-1];
    st    = ST_OK;
    if (den_r[0] == '0) begin
      y  = neg_r ? Y_MIN : Y_MAX;
      st = ST_A0_ZERO;
    end else if (sat_hi_r) begin
      y  = q_neg ? Y_MIN : Y_MAX;
      st = ST_SAT;
    end else if (q_neg) begin
      if (quo_r[DATA_W-1] && (quo_r[DATA_W-2:0] != '0)) begin
        y  = Y_MIN;
        st = ST_SAT;
      end else begin
        y = ~quo_r + 1'b1;
      end
    end else begin
      if (quo_r[DATA_W-1]) begin
        y  = Y_MAX;
        st = ST_SAT;
      end else begin
        y = quo_r;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COEFS; i++) begin
        num_r[i] <= '0;
        den_r[i] <= '0;
      end
      den_r[0] <= DEN0_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_NUM0: num_r[0] <= cfg_wdata;
        REG_NUM1: num_r[1] <= cfg_wdata;
        REG_NUM2: num_r[2] <= cfg_wdata;
        REG_NUM3: num_r[3] <= cfg_wdata;
        REG_DEN0: den_r[0] <= cfg_wdata;
        REG_DEN1: den_r[1] <= cfg_wdata;
        REG_DEN2: den_r[2] <= cfg_wdata;
        REG_DEN3: den_r[3] <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Histories, newest first
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      for (int i = 0; i < HIST_DEPTH; i++) begin
        ih_r[i] <= '0;
        oh_r[i] <= '0;
      end
    end else if (cmd.finish) begin
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
        ih_r[i] <= ih_r[i-1];
        oh_r[i] <= oh_r[i-1];
      end
      ih_r[0] <= x_r;
      oh_r[0] <= y;
    end
  end

  // Arithmetic pipeline
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r   <= in_sample;
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      if (cmd.acc_sub) begin
        acc_r <= acc_r - ACC_W'(prod_r);
      end else begin
        acc_r <= acc_r + ACC_W'(prod_r);
      end
    end
    if (cmd.mul_en) begin
      prod_r <= coef_sel * data_sel;
    end
    if (cmd.abs_en) begin
      neg_r    <= acc_r[ACC_W-1];
      // quotient of 2^32 or more saturates at once
      sat_hi_r <= (mag[ACC_W-1:DATA_W] >= (ACC_W - DATA_W)'(divisor));
      rem_r    <= mag[2*DATA_W-1:DATA_W];
      quo_r    <= mag[DATA_W-1:0];
    end else if (cmd.div_en) begin
      rem_r <= trial_ge ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
      quo_r <= {quo_r[DATA_W-2:0], trial_ge};
    end
    if (cmd.finish) begin
      filt_r <= y;
      stat_r <= st;
    end
  end

endmodule
